FILE: rtl/qtpr_pkg.sv
// ----------------------------------------------------------------------------
// qtpr_pkg
// Shared types, constants and helpers of the quarter-turn pixel rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package qtpr_pkg;

    localparam int PANEL_WIDTH    = 1648;
    localparam int PANEL_HEIGHT   = 824;
    localparam int MAX_SOURCE_DIM = 4096;

    localparam int DIM_W     = 13;
    localparam int CNT_W     = $clog2(MAX_SOURCE_DIM);
    localparam int COORD_W   = CNT_W + 1;
    localparam int PX_W      = $clog2(PANEL_WIDTH);
    localparam int PY_W      = $clog2(PANEL_HEIGHT);
    localparam int ADDR_W    = 21;
    localparam int BYTE_W    = 8;
    localparam int RGB_W     = 3 * BYTE_W;
    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = DIM_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_W-1:0] OPAQUE_ALPHA = 8'hff;

    localparam logic [DIM_W-1:0] RESET_SOURCE_WIDTH  = 13'd824;
    localparam logic [DIM_W-1:0] RESET_SOURCE_HEIGHT = 13'd1648;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_WIDTH  = 2'd0,
        CFG_SOURCE_HEIGHT = 2'd1,
        CFG_QUARTER_TURNS = 2'd2,
        CFG_COLOUR_MODE   = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        TURN_NONE = 2'd0,
        TURN_90   = 2'd1,
        TURN_180  = 2'd2,
        TURN_270  = 2'd3
    } turn_t;

    typedef enum logic [1:0] {
        COMP_RED   = 2'd0,
        COMP_GREEN = 2'd1,
        COMP_BLUE  = 2'd2,
        COMP_SPARE = 2'd3
    } comp_t;

    typedef struct packed {
        logic [PX_W-1:0]  dx;
        logic [PY_W-1:0]  dy;
        logic             on_panel;
        logic             done;
        logic [RGB_W-1:0] rgb;
    } pixel_entry_t;

    function automatic logic [DIM_W-1:0] effective_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (32'(v) > 32'(MAX_SOURCE_DIM))
            r = DIM_W'(MAX_SOURCE_DIM);
        else
            r = v;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/quarter_turn_pixel_rotator_top.sv
// ----------------------------------------------------------------------------
// quarter_turn_pixel_rotator_top
// Rotates a raster source image by quarter turns onto a landscape panel.
// ----------------------------------------------------------------------------
// Takes one source byte per clock while in_ready is high. In grey mode every
// byte yields one result; in RGB mode every third (blue) byte does. The front
// updates its position counters and rotation in the cycle a byte is taken and
// pushes the pixel into a four-entry queue; the back pops it when the output
// register is free or being taken, forms the panel address and loads the
// output register. With the output stalled, the output register and the
// queue hold five results before in_ready drops.
// Clipped points carry address 0 with write_enable low. Configuration must
// be written by the user only while no beat is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module quarter_turn_pixel_rotator_top
    import qtpr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output      logic                  in_ready,
    input  wire logic [BYTE_W-1:0]     source_byte,
    output      logic                  out_valid,
    input  wire logic                  out_ready,
    output      logic [ADDR_W-1:0]     panel_address,
    output      logic [WORD_W-1:0]     pixel_word,
    output      logic                  write_enable,
    output      logic                  frame_done
);

    logic         q_push;
    logic         q_full;
    logic         q_pop;
    logic         q_empty;
    pixel_entry_t q_in;
    pixel_entry_t q_head;

    qtpr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .source_byte (source_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (q_in)
    );

    qtpr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head       (q_head)
    );

    qtpr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .panel_address (panel_address),
        .pixel_word    (pixel_word),
        .write_enable  (write_enable),
        .frame_done    (frame_done)
    );

endmodule

`default_nettype wire

FILE: rtl/qtpr_front.sv
// ----------------------------------------------------------------------------
// qtpr_front
// Config registers, colour assembly, source position counters and rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module qtpr_front
    import qtpr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output      logic                  in_ready,
    input  wire logic [BYTE_W-1:0]     source_byte,
    input  wire logic                  q_full,
    output      logic                  q_push,
    output      pixel_entry_t          q_entry
);

    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    turn_t             turns_reg;
    logic              mode_reg;

    logic [CNT_W-1:0]  col_reg, col_next;
    logic [CNT_W-1:0]  row_reg, row_next;
    comp_t             comp_reg, comp_next;
    logic [BYTE_W-1:0] red_reg, red_next;
    logic [BYTE_W-1:0] green_reg, green_next;

    logic                       accept;
    logic                       is_pixel;
    logic [DIM_W-1:0]           w_eff;
    logic [DIM_W-1:0]           h_eff;
    logic signed [COORD_W-1:0]  x_s, y_s, wm1_s, hm1_s, dx_s, dy_s;
    logic                       on_panel;
    logic                       last_col;
    logic                       last_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_SOURCE_WIDTH;
            height_reg <= RESET_SOURCE_HEIGHT;
            turns_reg  <= TURN_270;
            mode_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SOURCE_WIDTH:  width_reg  <= cfg_data;
                CFG_SOURCE_HEIGHT: height_reg <= cfg_data;
                CFG_QUARTER_TURNS: turns_reg  <= turn_t'(cfg_data[1:0]);
                CFG_COLOUR_MODE:   mode_reg   <= cfg_data[0];
            endcase
        end
    end

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        w_eff = effective_dim(width_reg);
        h_eff = effective_dim(height_reg);
        x_s   = $signed({1'b0, col_reg});
        y_s   = $signed({1'b0, row_reg});
        wm1_s = $signed(w_eff - DIM_W'(1));
        hm1_s = $signed(h_eff - DIM_W'(1));

        unique case (turns_reg)
            TURN_90:
            begin
                dx_s = hm1_s - y_s;
                dy_s = x_s;
            end
            TURN_180:
            begin
                dx_s = wm1_s - x_s;
                dy_s = hm1_s - y_s;
            end
            TURN_270:
            begin
                dx_s = y_s;
                dy_s = wm1_s - x_s;
            end
            TURN_NONE:
            begin
                dx_s = x_s;
                dy_s = y_s;
            end
        endcase

        on_panel = !dx_s[COORD_W-1] && (32'(dx_s[COORD_W-2:0]) < 32'(PANEL_WIDTH))
                && !dy_s[COORD_W-1] && (32'(dy_s[COORD_W-2:0]) < 32'(PANEL_HEIGHT));

        last_col = ({1'b0, col_reg} + DIM_W'(1)) >= w_eff;
        last_row = ({1'b0, row_reg} + DIM_W'(1)) >= h_eff;

        is_pixel   = !mode_reg || (comp_reg != COMP_RED && comp_reg != COMP_GREEN);
        comp_next  = comp_reg;
        red_next   = red_reg;
        green_next = green_reg;
        col_next   = col_reg;
        row_next   = row_reg;

        if (accept)
        begin
            if (mode_reg && comp_reg == COMP_RED)
            begin
                red_next  = source_byte;
                comp_next = COMP_GREEN;
            end
            else if (mode_reg && comp_reg == COMP_GREEN)
            begin
                green_next = source_byte;
                comp_next  = COMP_BLUE;
            end
            else
            begin
                comp_next = COMP_RED;
                if (last_col)
                begin
                    col_next = '0;
                    row_next = last_row ? '0 : row_reg + CNT_W'(1);
                end
                else
                begin
                    col_next = col_reg + CNT_W'(1);
                end
            end
        end

        q_push           = accept && is_pixel;
        q_entry.dx       = on_panel ? dx_s[PX_W-1:0] : '0;
        q_entry.dy       = on_panel ? dy_s[PY_W-1:0] : '0;
        q_entry.on_panel = on_panel;
        q_entry.done     = last_col && last_row;
        q_entry.rgb      = mode_reg ? {red_reg, green_reg, source_byte}
                                    : {source_byte, source_byte, source_byte};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            comp_reg  <= COMP_RED;
            red_reg   <= '0;
            green_reg <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            comp_reg  <= comp_next;
            red_reg   <= red_next;
            green_reg <= green_next;
        end
    end

`ifndef SYNTHESIS
    a_comp_never_spare: assert property (@(posedge clk) disable iff (!rst_n)
        comp_reg != COMP_SPARE)
        else $error("component index reached unused code");

    a_done_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && q_entry.done |=> col_reg == '0 && row_reg == '0)
        else $error("counters did not wrap after frame end");

    a_no_push_on_rg: assert property (@(posedge clk) disable iff (!rst_n)
        accept && mode_reg && (comp_reg == COMP_RED || comp_reg == COMP_GREEN)
        |-> !q_push)
        else $error("pixel pushed before blue byte");
`endif

endmodule

`default_nettype wire

FILE: rtl/qtpr_queue.sv
// ----------------------------------------------------------------------------
// qtpr_queue
// Short flop-based queue of rotated pixels between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module qtpr_queue
    import qtpr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire pixel_entry_t push_entry,
    output      logic  full,
    input  wire logic  pop,
    output      logic  empty,
    output pixel_entry_t head
);

    pixel_entry_t      mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= QUEUE_DEPTH)
        else $error("queue count out of range");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        QPTR_W'(rd_ptr_reg + QPTR_W'(count_reg)) == wr_ptr_reg)
        else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

FILE: rtl/qtpr_back.sv
// ----------------------------------------------------------------------------
// qtpr_back
// Panel address generation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qtpr_back
    import qtpr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_empty,
    input  wire pixel_entry_t       q_head,
    output      logic               q_pop,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic [ADDR_W-1:0]  panel_address,
    output      logic [WORD_W-1:0]  pixel_word,
    output      logic               write_enable,
    output      logic               frame_done
);

    logic              valid_reg, valid_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [WORD_W-1:0] word_reg;
    logic              we_reg;
    logic              done_reg;
    logic [ADDR_W-1:0] addr_calc;

    always_comb
    begin
        q_pop      = !q_empty && (!valid_reg || out_ready);
        addr_calc  = ADDR_W'(q_head.dy) * ADDR_W'(PANEL_WIDTH) + ADDR_W'(q_head.dx);
        valid_next = q_pop ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            addr_reg <= addr_calc;
            word_reg <= {OPAQUE_ALPHA, q_head.rgb};
            we_reg   <= q_head.on_panel;
            done_reg <= q_head.done;
        end
    end

    assign out_valid     = valid_reg;
    assign panel_address = addr_reg;
    assign pixel_word    = word_reg;
    assign write_enable  = we_reg;
    assign frame_done    = done_reg;

`ifndef SYNTHESIS
    a_clipped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && !q_head.on_panel |=> panel_address == '0 && !write_enable)
        else $error("clipped pixel carries nonzero address");

    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(panel_address) < PANEL_WIDTH * PANEL_HEIGHT)
        else $error("panel address out of range");

    a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty && !out_valid |-> q_pop)
        else $error("back stalled with free output register");
`endif

endmodule

`default_nettype wire
